[hdl/smx_pkg.sv]
// shared constants and control types for the splitmix64 choice generator
`timescale 1ns / 1ps
`default_nettype none
package smx_pkg;

  localparam int unsigned WORD_W = 64;
  localparam int unsigned HALF_W = WORD_W / 2;

  localparam logic [WORD_W-1:0] GOLDEN_GAMMA = 64'h9E3779B97F4A7C15;
  localparam logic [WORD_W-1:0] MIX_MUL_A    = 64'hBF58476D1CE4E5B9;
  localparam logic [WORD_W-1:0] MIX_MUL_B    = 64'h94D049BB133111EB;
  localparam int unsigned MIX_SHIFT_A = 30;
  localparam int unsigned MIX_SHIFT_B = 27;
  localparam int unsigned MIX_SHIFT_C = 31;

  localparam int unsigned DIV_CNT_W = $clog2(WORD_W);

  // partial product selection
  localparam logic [1:0] MUL_NONE = 2'd0;
  localparam logic [1:0] MUL_LL   = 2'd1;
  localparam logic [1:0] MUL_LH   = 2'd2;
  localparam logic [1:0] MUL_HL   = 2'd3;

  // accumulator operation
  localparam logic [1:0] ACC_NONE    = 2'd0;
  localparam logic [1:0] ACC_LOAD    = 2'd1;
  localparam logic [1:0] ACC_ADD_HI  = 2'd2;

  typedef struct packed {
    logic       cap_bound;
    logic       advance;
    logic       mix_b;
    logic       mix_fin;
    logic       div_step;
    logic       out_load;
    logic       out_zero;
    logic       ksel_b;
    logic [1:0] mul_op;
    logic [1:0] acc_op;
  } cmd_t;

  typedef struct packed {
    logic bound_zero;
  } status_t;

endpackage
`default_nettype wire

[hdl/smx_dp.sv]
// datapath: generator state, split multiplier, radix-2 remainder unit, result register
`timescale 1ns / 1ps
`default_nettype none
module smx_dp import smx_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              seed_wr,
  input  wire logic [WORD_W-1:0] seed,
  input  wire logic [WORD_W-1:0] bound,
  input  wire cmd_t              cmd,
  output status_t                status,
  output logic      [WORD_W-1:0] choice
);

  logic [WORD_W-1:0] rng_state;
  logic [WORD_W-1:0] bound_reg;
  logic [WORD_W-1:0] mop;
  logic [WORD_W-1:0] prod;
  logic [WORD_W-1:0] acc;
  logic [WORD_W-1:0] z;
  logic [WORD_W-1:0] rem;

  logic [WORD_W-1:0] state_adv;
  logic [WORD_W-1:0] kmul;
  logic [HALF_W-1:0] mul_a;
  logic [HALF_W-1:0] mul_b;
  logic [WORD_W:0]   rem_sh;
  logic [WORD_W:0]   rem_sub;

  assign status.bound_zero = (bound == '0);
  assign state_adv = rng_state + GOLDEN_GAMMA;
  assign kmul      = cmd.ksel_b ? MIX_MUL_B : MIX_MUL_A;

  always_comb begin
    case (cmd.mul_op)
      MUL_LH: begin
        mul_a = mop[HALF_W-1:0];
        mul_b = kmul[WORD_W-1:HALF_W];
      end
      MUL_HL: begin
        mul_a = mop[WORD_W-1:HALF_W];
        mul_b = kmul[HALF_W-1:0];
      end
      default: begin
        mul_a = mop[HALF_W-1:0];
        mul_b = kmul[HALF_W-1:0];
      end
    endcase
  end

  assign rem_sh  = {rem, z[WORD_W-1]};
  assign rem_sub = rem_sh - {1'b0, bound_reg};

  always_ff @(posedge clk) begin
    if (rst) begin
      rng_state <= '0;
    end else if (seed_wr) begin
      rng_state <= seed;
    end else if (cmd.advance) begin
      rng_state <= state_adv;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_bound) begin
      bound_reg <= bound;
    end
    if (cmd.advance) begin
      mop <= state_adv ^ (state_adv >> MIX_SHIFT_A);
    end else if (cmd.mix_b) begin
      mop <= acc ^ (acc >> MIX_SHIFT_B);
    end
    if (cmd.mul_op != MUL_NONE) begin
      prod <= WORD_W'(mul_a) * WORD_W'(mul_b);
    end
    case (cmd.acc_op)
      ACC_LOAD:   acc <= prod;
      ACC_ADD_HI: acc <= acc + {prod[HALF_W-1:0], {HALF_W{1'b0}}};
      default:    acc <= acc;
    endcase
    if (cmd.mix_fin) begin
      z   <= acc ^ (acc >> MIX_SHIFT_C);
      rem <= '0;
    end else if (cmd.div_step) begin
      z <= {z[WORD_W-2:0], 1'b0};
      if (!rem_sub[WORD_W]) begin
        rem <= rem_sub[WORD_W-1:0];
      end else begin
        rem <= rem_sh[WORD_W-1:0];
      end
    end
    if (cmd.out_load) begin
      choice <= cmd.out_zero ? '0 : rem;
    end
  end

endmodule
`default_nettype wire

[hdl/smx_ctrl.sv]
// controller: sequences advance, two multiply rounds, remainder loop and result handoff
`timescale 1ns / 1ps
`default_nettype none
module smx_ctrl import smx_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  output logic         in_stall,
  output logic         out_valid,
  input  wire logic    out_stall,
  input  wire status_t status,
  output cmd_t         cmd
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_ADV  = 4'd1;
  localparam logic [3:0] S_MUL0 = 4'd2;
  localparam logic [3:0] S_MUL1 = 4'd3;
  localparam logic [3:0] S_MUL2 = 4'd4;
  localparam logic [3:0] S_MUL3 = 4'd5;
  localparam logic [3:0] S_MIXB = 4'd6;
  localparam logic [3:0] S_FIN  = 4'd7;
  localparam logic [3:0] S_DIV  = 4'd8;
  localparam logic [3:0] S_DONE = 4'd9;

  logic [3:0]           state;
  logic [3:0]           state_next;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 round;
  logic                 zero;
  logic                 out_free;

  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    cmd        = '0;
    cmd.ksel_b = round;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.cap_bound = 1'b1;
          state_next = status.bound_zero ? S_DONE : S_ADV;
        end
      end
      S_ADV: begin
        cmd.advance = 1'b1;
        state_next = S_MUL0;
      end
      S_MUL0: begin
        cmd.mul_op = MUL_LL;
        state_next = S_MUL1;
      end
      S_MUL1: begin
        cmd.mul_op = MUL_LH;
        cmd.acc_op = ACC_LOAD;
        state_next = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul_op = MUL_HL;
        cmd.acc_op = ACC_ADD_HI;
        state_next = S_MUL3;
      end
      S_MUL3: begin
        cmd.acc_op = ACC_ADD_HI;
        if (round) begin
          state_next = S_FIN;
        end else begin
          state_next = S_MIXB;
        end
      end
      S_MIXB: begin
        cmd.mix_b = 1'b1;
        state_next = S_MUL0;
      end
      S_FIN: begin
        cmd.mix_fin = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt == '0) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_zero = zero;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      round     <= 1'b0;
      zero      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_IDLE && in_valid) begin
        zero  <= status.bound_zero;
        round <= 1'b0;
      end
      if (state == S_MUL3) begin
        round <= 1'b1;
      end
      if (state == S_FIN) begin
        cnt <= DIV_CNT_W'(WORD_W - 1);
      end else if (state == S_DIV) begin
        cnt <= cnt - DIV_CNT_W'(1);
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

[hdl/splitmix64_bounded_choice_core.sv]
// top level of the seeded splitmix64 bounded choice generator
//
//   port group   dir   handshake              payload
//   in           in    in_valid / in_stall    bound[63:0]
//   out          out   out_valid / out_stall  choice[63:0]
//   seed write   in    seed_wr                seed[63:0]
//
// a nonzero bound passes after acceptance through one advance, two rounds of 32x32
// multiplies, the mid and final mixes, 64 remainder steps and one handoff of the
// waiting result; the next item is taken after the handoff, zero bounds skip to it
// rst clears the generator state to zero and the result register to empty
// a held result keeps its value; a new item is taken while it waits, and the
// handoff of the next result waits until it is taken
`timescale 1ns / 1ps
`default_nettype none
module splitmix64_bounded_choice_core import smx_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              seed_wr,
  input  wire logic [WORD_W-1:0] seed,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [WORD_W-1:0] bound,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic      [WORD_W-1:0] choice
);

  cmd_t    cmd;
  status_t status;

  smx_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  smx_dp u_dp (
    .clk     (clk),
    .rst     (rst),
    .seed_wr (seed_wr),
    .seed    (seed),
    .bound   (bound),
    .cmd     (cmd),
    .status  (status),
    .choice  (choice)
  );

endmodule
`default_nettype wire

[test/splitmix64_bounded_choice_core_tb.sv]
// testbench for the splitmix64 bounded choice core: directed and random bounds checked against a local predictor
`timescale 1ns / 1ps
module splitmix64_bounded_choice_core_tb;

  localparam int unsigned W = smx_pkg::WORD_W;
  localparam logic [W-1:0] GAMMA_INC = 64'h9E3779B97F4A7C15;
  localparam logic [W-1:0] MIX_MULT_1 = 64'hBF58476D1CE4E5B9;
  localparam logic [W-1:0] MIX_MULT_2 = 64'h94D049BB133111EB;
  localparam int unsigned MIX_SHIFT_1 = 30;
  localparam int unsigned MIX_SHIFT_2 = 27;
  localparam int unsigned MIX_SHIFT_3 = 31;
  localparam int unsigned QUIET_LIMIT = 4000;
  localparam int unsigned PHASE_ITEMS = 577;
  localparam int unsigned RING_AW = 6;
  localparam int unsigned RING_DEPTH = 1 << RING_AW;
  localparam logic [W-1:0] ALL_ONES = {W{1'b1}};

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic seed_wr = 1'b0;
  logic [W-1:0] seed = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [W-1:0] bound = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [W-1:0] choice;

  logic [W-1:0] gen_state;
  logic [W-1:0] choice_ring [RING_DEPTH];
  int unsigned ring_wr = 0;
  int unsigned ring_rd = 0;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned mismatch_count = 0;
  int unsigned quiet_cycles = 0;

  splitmix64_bounded_choice_core dut (
    .clk(clk),
    .rst(rst),
    .seed_wr(seed_wr),
    .seed(seed),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .bound(bound),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .choice(choice)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic [W-1:0] predict_choice(input logic [W-1:0] b);
    logic [W-1:0] z;
    if (b == '0) return '0;
    gen_state = gen_state + GAMMA_INC;
    z = gen_state;
    z = (z ^ (z >> MIX_SHIFT_1)) * MIX_MULT_1;
    z = (z ^ (z >> MIX_SHIFT_2)) * MIX_MULT_2;
    z = z ^ (z >> MIX_SHIFT_3);
    return z % b;
  endfunction

  function automatic logic [W-1:0] pick_bound();
    case ($urandom_range(9))
      0: return '0;
      1: return W'($urandom_range(16, 1));
      2: return {32'h0, $urandom()};
      3: return W'(1) << $urandom_range(W - 1);
      4: return ALL_ONES - W'($urandom_range(3));
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [W-1:0] got,
                                 input logic [W-1:0] want);
    $display("%0t: %s: got %h expected %h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  task automatic send_bound(input logic [W-1:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    bound <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    choice_ring[ring_wr[RING_AW-1:0]] = predict_choice(b);
    ring_wr++;
  endtask

  task automatic wait_for_choices();
    if (in_valid) in_valid <= 1'b0;
    do @(posedge clk); while (ring_wr != ring_rd);
  endtask

  task automatic reseed(input logic [W-1:0] v);
    wait_for_choices();
    seed_wr <= 1'b1;
    seed <= v;
    @(posedge clk);
    seed_wr <= 1'b0;
    gen_state = v;
  endtask

  // state is zero out of reset, no seed write yet
  task automatic test_reset_state();
    send_bound(64'd1);
    send_bound(64'd0);
    send_bound(64'd5);
    send_bound(64'd0);
    send_bound(64'd0);
  endtask

  task automatic test_bound_extremes();
    reseed(ALL_ONES);
    send_bound(ALL_ONES);
    send_bound(64'h8000_0000_0000_0000);
    send_bound(64'h0000_0001_0000_0000);
    send_bound(64'd2);
    send_bound(64'd1);
    send_bound(64'd0);
    send_bound(ALL_ONES - 64'd1);
    send_bound(64'd3);
  endtask

  // rewriting the same seed must restart the sequence
  task automatic test_seed_reload();
    reseed('0);
    send_bound(ALL_ONES);
    reseed('0);
    send_bound(ALL_ONES);
    reseed(64'h5555_5555_5555_5555);
    send_bound(64'd1000);
    reseed(64'hAAAA_AAAA_AAAA_AAAA);
    send_bound(64'd0);
    send_bound(ALL_ONES);
  endtask

  task automatic test_random_traffic(input int unsigned n, input int unsigned sp,
                                     input int unsigned rp);
    send_idle_pct = sp;
    recv_idle_pct = rp;
    reseed({$urandom(), $urandom()});
    for (int unsigned i = 0; i < n; i++) begin
      if ($urandom_range(149) == 0)
        reseed({$urandom(), $urandom()});
      else if ($urandom_range(59) == 0)
        wait_for_choices();
      send_bound(pick_bound());
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin : take_choice
        logic [W-1:0] want;
        if (ring_wr == ring_rd) begin
          report_mismatch("choice with no item pending", choice, '0);
        end else begin
          want = choice_ring[ring_rd[RING_AW-1:0]];
          ring_rd++;
          if (choice !== want) report_mismatch("choice", choice, want);
        end
      end
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    gen_state = '0;
    send_idle_pct = 36;
    recv_idle_pct = 52;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_state();
    test_bound_extremes();
    test_seed_reload();
    test_random_traffic(PHASE_ITEMS, 36, 52);
    test_random_traffic(PHASE_ITEMS, 52, 36);
    test_random_traffic(PHASE_ITEMS, 0, 0);
    wait_for_choices();
    repeat (100) @(posedge clk);
    if (mismatch_count == 0 && ring_wr == ring_rd) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[files.f]
hdl/smx_pkg.sv
hdl/smx_dp.sv
hdl/smx_ctrl.sv
hdl/splitmix64_bounded_choice_core.sv
test/splitmix64_bounded_choice_core_tb.sv
